>>> sv/vstk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vstk_pkg
// sizes, request and status codes and helpers of the vector element stack
// ----------------------------------------------------------------------------
package vstk_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int MAX_WORDS   = 4;

    localparam int IO_WORDS  = 4;
    localparam int WORD_W    = 32;
    localparam int CNT_W     = 11;
    localparam int DEPTH_W   = 11;
    localparam int REQ_W     = 3;
    localparam int STATUS_W  = 2;
    localparam int CFG_W     = 3;
    localparam int ADDR_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SP_W      = $clog2(STACK_DEPTH + 1);
    localparam int CMP_W     = (SP_W > CNT_W) ? SP_W : CNT_W;
    localparam int LIM_WORDS = (MAX_WORDS < IO_WORDS) ? MAX_WORDS : IO_WORDS;
    localparam int RAM_WORDS = LIM_WORDS;

    localparam int PAYLOAD_W = IO_WORDS * WORD_W + CNT_W;
    localparam int TDATA_W   = ((PAYLOAD_W + 7) / 8) * 8;
    localparam int PAD_W     = TDATA_W - PAYLOAD_W;

    localparam logic [REQ_W-1:0] REQ_PUSH    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_POP     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_TOP     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_PEEK    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DISCARD = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_PEEK_OOR  = 2'd3;

    localparam logic [CFG_W-1:0] EW_RESET = 3'd1;
    localparam logic [CFG_W-1:0] EW_LIM   = CFG_W'(LIM_WORDS);

    function automatic logic [CFG_W-1:0] eff_words(input logic [CFG_W-1:0] ew);
        logic [CFG_W-1:0] w;
        w = ew;
        if (w == '0) begin
            w = 3'd1;
        end
        if (w > EW_LIM) begin
            w = EW_LIM;
        end
        return w;
    endfunction

endpackage

>>> sv/vstk_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vstk_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module vstk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/vector_element_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_element_stack
// lifo stack of vector elements with top, peek and discard
// ----------------------------------------------------------------------------
// requests come in on the s_ channel (kind in s_tuser, element words and
// count in s_tdata); every request gives exactly one result on the m_
// channel with the element read (if any), the stack size and a status in
// m_tuser. elements live in one ram per element word, one row per entry.
// the element width is set through the cfg_ channel; the user must set it
// only while the block is idle, which the block does not enforce. cfg_ready
// is always high. push, discard and every failed request go straight to the
// output register, valid in the cycle after the transfer; pop, top and peek
// first pass through the read state (s_tready low) for the registered ram
// read port. a request is taken only after the previous one has produced its
// result; push and discard can follow every cycle unless the output stalls.
// the result waits in an output register; while the receiver stalls it holds
// and s_tready stays low. reset empties the stack and sets the element width
// to one word; the ram contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module vector_element_stack (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // word0, word1, word2, word3, count, zero pad
    input  logic [vstk_pkg::TDATA_W-1:0]  s_tdata,
    // req_type
    input  logic [vstk_pkg::REQ_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_word0, out_word1, out_word2, out_word3, depth_now, zero pad
    output logic [vstk_pkg::TDATA_W-1:0]  m_tdata,
    // status
    output logic [vstk_pkg::STATUS_W-1:0] m_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [vstk_pkg::CFG_W-1:0]    cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t                          state_reg, state_next;
    logic [vstk_pkg::SP_W-1:0]       sp_reg, sp_next;
    logic [vstk_pkg::CFG_W-1:0]      ew_reg;
    logic                            mvalid_reg, mvalid_next;
    logic [vstk_pkg::WORD_W-1:0]     oword_reg [vstk_pkg::IO_WORDS];
    logic [vstk_pkg::WORD_W-1:0]     oword_next [vstk_pkg::IO_WORDS];
    logic [vstk_pkg::DEPTH_W-1:0]    depth_reg, depth_next;
    logic [vstk_pkg::STATUS_W-1:0]   status_reg, status_next;

    logic                            s_xfer;
    logic [vstk_pkg::REQ_W-1:0]      req;
    logic [vstk_pkg::CNT_W-1:0]      cnt;
    logic [vstk_pkg::WORD_W-1:0]     in_word [vstk_pkg::IO_WORDS];
    logic [vstk_pkg::CMP_W-1:0]      sp_ext, cnt_ext;
    logic [vstk_pkg::CFG_W-1:0]      eff;
    logic                            push_ok, rd_ok;
    logic [vstk_pkg::CMP_W-1:0]      rd_row;
    logic [vstk_pkg::WORD_W-1:0]     rd_word [vstk_pkg::IO_WORDS];

    assign s_xfer    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE) && (!mvalid_reg || m_tready);
    assign cfg_ready = 1'b1;
    assign req       = s_tuser;
    assign cnt       = s_tdata[vstk_pkg::IO_WORDS*vstk_pkg::WORD_W +: vstk_pkg::CNT_W];
    assign sp_ext    = vstk_pkg::CMP_W'(sp_reg);
    assign cnt_ext   = vstk_pkg::CMP_W'(cnt);
    assign eff       = vstk_pkg::eff_words(ew_reg);

    always_comb begin
        state_next  = state_reg;
        sp_next     = sp_reg;
        mvalid_next = mvalid_reg;
        depth_next  = depth_reg;
        status_next = status_reg;
        push_ok     = 1'b0;
        rd_ok       = 1'b0;
        rd_row      = sp_ext - vstk_pkg::CMP_W'(1);
        for (int j = 0; j < vstk_pkg::IO_WORDS; j++) begin
            oword_next[j] = oword_reg[j];
        end
        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    status_next = vstk_pkg::STAT_OK;
                    case (req)
                        vstk_pkg::REQ_PUSH: begin
                            if (sp_ext >= vstk_pkg::CMP_W'(vstk_pkg::STACK_DEPTH)) begin
                                status_next = vstk_pkg::STAT_OVERFLOW;
                            end else begin
                                push_ok = 1'b1;
                                sp_next = sp_reg + vstk_pkg::SP_W'(1);
                            end
                        end
                        vstk_pkg::REQ_POP: begin
                            if (sp_reg == '0) begin
                                status_next = vstk_pkg::STAT_UNDERFLOW;
                            end else begin
                                rd_ok   = 1'b1;
                                sp_next = sp_reg - vstk_pkg::SP_W'(1);
                            end
                        end
                        vstk_pkg::REQ_TOP: begin
                            if (sp_reg == '0) begin
                                status_next = vstk_pkg::STAT_UNDERFLOW;
                            end else begin
                                rd_ok = 1'b1;
                            end
                        end
                        vstk_pkg::REQ_PEEK: begin
                            if (cnt_ext >= sp_ext) begin
                                status_next = vstk_pkg::STAT_PEEK_OOR;
                            end else begin
                                rd_ok  = 1'b1;
                                rd_row = sp_ext - vstk_pkg::CMP_W'(1) - cnt_ext;
                            end
                        end
                        vstk_pkg::REQ_DISCARD: begin
                            if (cnt_ext > sp_ext) begin
                                status_next = vstk_pkg::STAT_UNDERFLOW;
                            end else begin
                                sp_next = vstk_pkg::SP_W'(sp_ext - cnt_ext);
                            end
                        end
                        default: begin
                        end
                    endcase
                    depth_next = vstk_pkg::DEPTH_W'(sp_next);
                    for (int j = 0; j < vstk_pkg::IO_WORDS; j++) begin
                        oword_next[j] = '0;
                    end
                    if (rd_ok) begin
                        state_next = ST_READ;
                    end else begin
                        mvalid_next = 1'b1;
                    end
                end
            end
            ST_READ: begin
                for (int j = 0; j < vstk_pkg::IO_WORDS; j++) begin
                    oword_next[j] = (vstk_pkg::CFG_W'(j) < eff) ? rd_word[j] : '0;
                end
                mvalid_next = 1'b1;
                state_next  = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // element rams, one per stored word
    for (genvar j = 0; j < vstk_pkg::IO_WORDS; j++) begin : g_word
        assign in_word[j] = s_tdata[j*vstk_pkg::WORD_W +: vstk_pkg::WORD_W];
        if (j < vstk_pkg::RAM_WORDS) begin : g_ram
            vstk_ram #(
                .WIDTH (vstk_pkg::WORD_W),
                .DEPTH (vstk_pkg::STACK_DEPTH)
            ) u_ram (
                .clk   (aclk),
                .we    (push_ok && (vstk_pkg::CFG_W'(j) < eff)),
                .waddr (sp_reg[vstk_pkg::ADDR_W-1:0]),
                .wdata (in_word[j]),
                .re    (rd_ok),
                .raddr (rd_row[vstk_pkg::ADDR_W-1:0]),
                .rdata (rd_word[j])
            );
        end else begin : g_none
            assign rd_word[j] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            sp_reg     <= '0;
            ew_reg     <= vstk_pkg::EW_RESET;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            sp_reg     <= sp_next;
            mvalid_reg <= mvalid_next;
            if (cfg_valid && cfg_ready) begin
                ew_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        depth_reg  <= depth_next;
        status_reg <= status_next;
        for (int j = 0; j < vstk_pkg::IO_WORDS; j++) begin
            oword_reg[j] <= oword_next[j];
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {{vstk_pkg::PAD_W{1'b0}}, depth_reg,
                       oword_reg[3], oword_reg[2], oword_reg[1], oword_reg[0]};

    a_read_output_free : assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |-> !mvalid_reg)
        else $error("read in flight while output register full");

    a_sp_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        sp_ext <= vstk_pkg::CMP_W'(vstk_pkg::STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_fail_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        mvalid_reg && status_reg != vstk_pkg::STAT_OK
        |-> m_tdata[vstk_pkg::IO_WORDS*vstk_pkg::WORD_W-1:0] == '0)
        else $error("failed request returned element data");

    a_fail_keeps_sp : assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer && status_next != vstk_pkg::STAT_OK |=> $stable(sp_reg))
        else $error("failed request changed the stack size");

endmodule
